FILE: rtl/tbce_pkg.sv
// Shared types and constants of the tail-biting convolutional encoder.
package tbce_pkg;

    localparam int GEN_W      = 16;
    localparam int CL_W       = 5;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int TDATA_W    = 8;

    localparam logic [GEN_W-1:0] GEN_A_RESET = 16'd91;
    localparam logic [GEN_W-1:0] GEN_B_RESET = 16'd121;
    localparam logic [CL_W-1:0]  CL_RESET    = 5'd7;

    typedef enum logic [1:0] {
        REG_GEN_A      = 2'd0,
        REG_GEN_B      = 2'd1,
        REG_CONSTRAINT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [GEN_W-1:0] generator_a;
        logic [GEN_W-1:0] generator_b;
        logic [CL_W-1:0]  constraint_length;
    } cfg_t;

    typedef struct packed {
        logic tail_active;
        logic frame_open;
    } stat_t;

endpackage

FILE: rtl/tail_biting_conv_encoder.sv
// Top level of the rate one-half tail-biting convolutional encoder.
//
// Information bits enter on the s_ stream, one bit per transaction, with
// s_tlast on the last bit of a frame. Code pairs leave on the m_ stream:
// m_tdata[1:0] = {code_bit_b, code_bit_a}, m_tlast on the final pair and
// m_tuser set on the single result of a frame of K bits or fewer.
// The APB port holds generator_a (0x0), generator_b (0x4) and
// constraint_length K (0x8); write them only while no frame is in flight.
// Throughput is one bit per cycle unless a tail wrap or a receiver stall
// holds the flow; a code pair appears in the cycle after its bit is taken.
// The first K bits of a frame load the register and give no output. On the
// frame's last bit the saved head bits are replayed: s_tready stays low for
// the wrap; K tail pairs leave the single result register, one per cycle as taken.
// When the receiver stalls, the result register holds its pair and s_tready
// drops until the pair is taken; a new bit is accepted in the same cycle the
// pending pair leaves. Reset clears the frame state and the result valid flag and
// restores the register defaults (91, 121, 7).
module tail_biting_conv_encoder
    import tbce_pkg::*;
#(
    parameter int MAX_CONSTRAINT = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,  // [0] data_bit, [7:1] zero
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,  // [0] code_bit_a, [1] code_bit_b, [7:2] zero
    output logic                  m_tlast,
    output logic                  m_tuser   // [0] frame_error
);

    cfg_t  cfg;
    stat_t stat;
    logic  code_a;
    logic  code_b;

    tbce_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tbce_encoder #(
        .MAX_CONSTRAINT (MAX_CONSTRAINT)
    ) u_encoder (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_bit    (s_tdata[0]),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_code_a (code_a),
        .m_code_b (code_b),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .stat     (stat)
    );

    assign m_tdata = {{(TDATA_W-2){1'b0}}, code_b, code_a};

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tlast && (m_tdata == '0))
        else $error("error result carries code bits or tlast");

    a_tail_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.tail_active |-> !s_tready)
        else $error("input accepted during tail wrap");

    a_last_ends_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |-> !stat.tail_active)
        else $error("final pair sent while tail still active");

    a_tail_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.tail_active |-> stat.frame_open)
        else $error("tail wrap without an open frame");

endmodule

FILE: rtl/tbce_cfg.sv
// APB register file holding the generator masks and the constraint length.
module tbce_cfg
    import tbce_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_GEN_A:      cfg_next.generator_a       = pwdata[GEN_W-1:0];
                REG_GEN_B:      cfg_next.generator_b       = pwdata[GEN_W-1:0];
                REG_CONSTRAINT: cfg_next.constraint_length = pwdata[CL_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_GEN_A:      prdata = APB_DATA_W'(cfg_reg.generator_a);
            REG_GEN_B:      prdata = APB_DATA_W'(cfg_reg.generator_b);
            REG_CONSTRAINT: prdata = APB_DATA_W'(cfg_reg.constraint_length);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.generator_a       <= GEN_A_RESET;
            cfg_reg.generator_b       <= GEN_B_RESET;
            cfg_reg.constraint_length <= CL_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/tbce_encoder.sv
// Encoder datapath: shift register, head capture, tail wrap and result register.
module tbce_encoder
    import tbce_pkg::*;
#(
    parameter int MAX_CONSTRAINT = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               s_bit,
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic               m_code_a,
    output logic               m_code_b,
    output logic               m_tlast,
    output logic               m_tuser,
    output stat_t              stat
);

    localparam int KW = $clog2(MAX_CONSTRAINT + 1);
    localparam int IW = $clog2(MAX_CONSTRAINT);
    localparam int CW = (KW > CL_W) ? KW : CL_W;

    typedef logic [MAX_CONSTRAINT-1:0] sreg_t;

    sreg_t           sr_reg, sr_next;
    sreg_t           head_reg, head_next;
    logic [KW-1:0]   cnt_reg, cnt_next;
    logic [KW-1:0]   tail_cnt_reg, tail_cnt_next;
    logic            tail_reg, tail_next;
    logic            mvalid_reg, mvalid_next;
    logic            code_a_reg, code_a_next;
    logic            code_b_reg, code_b_next;
    logic            last_reg, last_next;
    logic            err_reg, err_next;

    logic [CW-1:0]   cl_ext;
    logic [KW-1:0]   k;
    logic [KW-1:0]   head_pos;
    sreg_t           kmask;
    sreg_t           sr_shift;
    logic            shift_bit;
    logic            out_free;
    logic            accept;
    logic            tail_step;
    logic            tail_last;
    logic            pair_a;
    logic            pair_b;

    always_comb begin
        cl_ext = CW'(cfg.constraint_length);
        if (cl_ext == '0) begin
            k = KW'(1);
        end else if (cl_ext > CW'(MAX_CONSTRAINT)) begin
            k = KW'(MAX_CONSTRAINT);
        end else begin
            k = KW'(cl_ext);
        end
    end

    always_comb begin
        for (int j = 0; j < MAX_CONSTRAINT; j++) begin
            kmask[j] = (KW'(j) < k);
        end
    end

    assign out_free  = !mvalid_reg || m_tready;
    assign s_tready  = !tail_reg && out_free;
    assign accept    = s_tvalid && s_tready;
    assign tail_step = tail_reg && out_free;
    assign tail_last = (tail_cnt_reg == (k - KW'(1)));
    assign head_pos  = k - KW'(1) - tail_cnt_reg;
    assign shift_bit = tail_reg ? head_reg[head_pos[IW-1:0]] : s_bit;
    assign sr_shift  = {sr_reg[MAX_CONSTRAINT-2:0], shift_bit};
    assign pair_a    = ^(sr_shift & kmask & sreg_t'(cfg.generator_a));
    assign pair_b    = ^(sr_shift & kmask & sreg_t'(cfg.generator_b));

    always_comb begin
        sr_next       = sr_reg;
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        tail_cnt_next = tail_cnt_reg;
        tail_next     = tail_reg;
        mvalid_next   = mvalid_reg && !m_tready;
        code_a_next   = code_a_reg;
        code_b_next   = code_b_reg;
        last_next     = last_reg;
        err_next      = err_reg;

        if (accept) begin
            sr_next = sr_shift;
            if (cnt_reg < k) begin
                cnt_next  = cnt_reg + KW'(1);
                head_next = sr_shift;
                if (s_tlast) begin
                    mvalid_next = 1'b1;
                    code_a_next = 1'b0;
                    code_b_next = 1'b0;
                    last_next   = 1'b0;
                    err_next    = 1'b1;
                    sr_next     = '0;
                    head_next   = '0;
                    cnt_next    = '0;
                end
            end else begin
                mvalid_next = 1'b1;
                code_a_next = pair_a;
                code_b_next = pair_b;
                last_next   = 1'b0;
                err_next    = 1'b0;
                if (s_tlast) begin
                    tail_next     = 1'b1;
                    tail_cnt_next = '0;
                end
            end
        end else if (tail_step) begin
            sr_next       = sr_shift;
            mvalid_next   = 1'b1;
            code_a_next   = pair_a;
            code_b_next   = pair_b;
            last_next     = tail_last;
            err_next      = 1'b0;
            tail_cnt_next = tail_cnt_reg + KW'(1);
            if (tail_last) begin
                tail_next     = 1'b0;
                tail_cnt_next = '0;
                sr_next       = '0;
                head_next     = '0;
                cnt_next      = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sr_reg       <= '0;
            head_reg     <= '0;
            cnt_reg      <= '0;
            tail_cnt_reg <= '0;
            tail_reg     <= 1'b0;
            mvalid_reg   <= 1'b0;
        end else begin
            sr_reg       <= sr_next;
            head_reg     <= head_next;
            cnt_reg      <= cnt_next;
            tail_cnt_reg <= tail_cnt_next;
            tail_reg     <= tail_next;
            mvalid_reg   <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_a_reg <= code_a_next;
        code_b_reg <= code_b_next;
        last_reg   <= last_next;
        err_reg    <= err_next;
    end

    assign m_tvalid         = mvalid_reg;
    assign m_code_a         = code_a_reg;
    assign m_code_b         = code_b_reg;
    assign m_tlast          = last_reg;
    assign m_tuser          = err_reg;
    assign stat.tail_active = tail_reg;
    assign stat.frame_open  = (cnt_reg != '0);

endmodule
